// ----- sv/rgb2g_pkg.sv -----
// shared types and constants of the rgb to gray byte stream converter
`default_nettype none

package rgb2g_pkg;

    localparam int CFG_W  = 14;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = 10;
    localparam int ADDR_W = 2;

    // floor(x/3) as (x * 683) >> 11, exact for x below 2048
    localparam int RECIP_W     = 10;
    localparam int RECIP_SHIFT = 11;
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(683);

    typedef enum logic [ADDR_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_SOURCE_FORMAT = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

    // one finished pixel waiting for the output register
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
        logic             row_end;
        logic             last_row;
        logic [1:0]       pad_out;
    } t_desc;

endpackage

`default_nettype wire

// ----- sv/rgb_to_gray_average_stream.sv -----
// top level: bitmap pixel bytes in, gray bytes with row padding out
// the pixel register takes a pixel's gray sum with its last colour byte, and the output
//   register takes the gray byte from it when neither back-pressure nor padding holds it
// throughput: one source byte per cycle; a row end's padding of up to three bytes holds
//   the output register, covered by the skipped source padding bytes and the bytes of
//   the next pixel, so the source is only stalled by output back-pressure
// reset: synchronous active low; all counters clear, registers go to width 1,
//   height 1, 24-bit format
`default_nettype none

module rgb_to_gray_average_stream
    import rgb2g_pkg::*;
#(
    parameter int MAX_DIM = 8192
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic              i_src_valid,
    output logic                   o_src_stall,
    input  wire logic [BYTE_W-1:0] i_src_byte,
    output logic                   o_gray_valid,
    input  wire logic              i_gray_stall,
    output logic [BYTE_W-1:0]      o_gray_byte,
    output logic                   o_is_padding,
    output logic                   o_row_last,
    output logic                   o_image_last,
    output logic                   o_run_last
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);
    localparam int PROD_W = SUM_W + RECIP_W;

    logic [CFG_W-1:0]  r_width, r_height;
    logic              r_fmt;
    logic [1:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [1:0]        r_skip, n_skip;
    logic [SUM_W-1:0]  r_sum, n_sum;
    t_desc             r_desc, n_desc;

    logic              r_o_valid, n_o_valid;
    logic [BYTE_W-1:0] r_o_gray, n_o_gray;
    logic              r_o_pad, n_o_pad;
    logic              r_o_rlast, n_o_rlast;
    logic              r_o_ilast, n_o_ilast;
    logic              r_o_runlast, n_o_runlast;
    logic [1:0]        r_pad_left, n_pad_left;
    logic              r_pad_lrow, n_pad_lrow;

    logic              src_acc, o_adv, d_take;
    logic [CMP_W-1:0]  w_eff, h_eff, col_nx, row_nx;
    logic [2:0]        ph3, fb3;
    logic [SUM_W-1:0]  sum_new;
    logic              last_row;
    logic [PROD_W-1:0] prod;

    // clamp the dimension registers into 1..MAX_DIM
    always_comb begin
        w_eff = CMP_W'(r_width);
        if (r_width == '0)
            w_eff = CMP_W'(1);
        else if (w_eff > DIM_MAX)
            w_eff = DIM_MAX;
        h_eff = CMP_W'(r_height);
        if (r_height == '0)
            h_eff = CMP_W'(1);
        else if (h_eff > DIM_MAX)
            h_eff = DIM_MAX;
    end

    assign col_nx   = CMP_W'(r_col) + CMP_W'(1);
    assign row_nx   = CMP_W'(r_row) + CMP_W'(1);
    assign last_row = (row_nx >= h_eff);
    assign ph3      = {1'b0, r_phase};
    assign fb3      = {2'b00, r_fmt};
    assign sum_new  = (ph3 == fb3) ? SUM_W'(i_src_byte) : r_sum + SUM_W'(i_src_byte);
    assign prod     = PROD_W'(r_desc.sum) * PROD_W'(RECIP_3);

    assign o_adv       = !r_o_valid || !i_gray_stall;
    assign d_take      = r_desc.valid && o_adv && (r_pad_left == 2'd0);
    assign o_src_stall = r_desc.valid && !d_take;
    assign src_acc     = i_src_valid && !o_src_stall;

    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_skip  = r_skip;
        n_sum   = r_sum;
        n_desc  = r_desc;
        if (d_take) begin
            n_desc.valid = 1'b0;
        end
        if (src_acc) begin
            if (r_skip != 2'd0) begin
                n_skip = r_skip - 2'd1;
            end else if (ph3 < fb3) begin
                n_phase = r_phase + 2'd1;
                n_sum   = '0;
            end else if (ph3 < fb3 + 3'd2) begin
                n_phase = r_phase + 2'd1;
                n_sum   = sum_new;
            end else begin
                // pixel complete
                n_phase         = '0;
                n_sum           = '0;
                n_desc.valid    = 1'b1;
                n_desc.sum      = sum_new;
                n_desc.pad_out  = 2'd0 - w_eff[1:0];
                n_desc.last_row = last_row;
                if (col_nx < w_eff) begin
                    n_col          = CNT_W'(col_nx);
                    n_desc.row_end = 1'b0;
                end else begin
                    n_col          = '0;
                    n_desc.row_end = 1'b1;
                    n_row          = last_row ? '0 : CNT_W'(row_nx);
                    n_skip         = r_fmt ? 2'd0 : w_eff[1:0];
                end
            end
        end
    end

    // output register: gray byte first, then the row's padding bytes
    always_comb begin
        n_o_valid   = r_o_valid;
        n_o_gray    = r_o_gray;
        n_o_pad     = r_o_pad;
        n_o_rlast   = r_o_rlast;
        n_o_ilast   = r_o_ilast;
        n_o_runlast = r_o_runlast;
        n_pad_left  = r_pad_left;
        n_pad_lrow  = r_pad_lrow;
        if (o_adv) begin
            if (r_pad_left != 2'd0) begin
                n_o_valid   = 1'b1;
                n_o_gray    = '0;
                n_o_pad     = 1'b1;
                n_o_rlast   = (r_pad_left == 2'd1);
                n_o_ilast   = (r_pad_left == 2'd1) && r_pad_lrow;
                n_o_runlast = (r_pad_left == 2'd1);
                n_pad_left  = r_pad_left - 2'd1;
            end else if (r_desc.valid) begin
                n_o_valid   = 1'b1;
                n_o_gray    = prod[RECIP_SHIFT +: BYTE_W];
                n_o_pad     = 1'b0;
                n_o_rlast   = r_desc.row_end && (r_desc.pad_out == 2'd0);
                n_o_ilast   = r_desc.row_end && (r_desc.pad_out == 2'd0) && r_desc.last_row;
                n_o_runlast = !r_desc.row_end || (r_desc.pad_out == 2'd0);
                n_pad_left  = r_desc.row_end ? r_desc.pad_out : 2'd0;
                n_pad_lrow  = r_desc.last_row;
            end else begin
                n_o_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= CFG_W'(1);
            r_height     <= CFG_W'(1);
            r_fmt        <= 1'b0;
            r_phase      <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_skip       <= '0;
            r_sum        <= '0;
            r_desc.valid <= 1'b0;
            r_o_valid    <= 1'b0;
            r_pad_left   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_IMAGE_WIDTH:   r_width  <= i_cfg_wdata;
                    REG_IMAGE_HEIGHT:  r_height <= i_cfg_wdata;
                    REG_SOURCE_FORMAT: r_fmt    <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            r_phase      <= n_phase;
            r_col        <= n_col;
            r_row        <= n_row;
            r_skip       <= n_skip;
            r_sum        <= n_sum;
            r_desc.valid <= n_desc.valid;
            r_o_valid    <= n_o_valid;
            r_pad_left   <= n_pad_left;
        end
        r_desc.sum      <= n_desc.sum;
        r_desc.row_end  <= n_desc.row_end;
        r_desc.last_row <= n_desc.last_row;
        r_desc.pad_out  <= n_desc.pad_out;
    end

    always_ff @(posedge i_clk) begin
        r_o_gray        <= n_o_gray;
        r_o_pad         <= n_o_pad;
        r_o_rlast       <= n_o_rlast;
        r_o_ilast       <= n_o_ilast;
        r_o_runlast     <= n_o_runlast;
        r_pad_lrow      <= n_pad_lrow;
    end

    assign o_gray_valid = r_o_valid;
    assign o_gray_byte  = r_o_gray;
    assign o_is_padding = r_o_pad;
    assign o_row_last   = r_o_rlast;
    assign o_image_last = r_o_ilast;
    assign o_run_last   = r_o_runlast;

endmodule

`default_nettype wire

// ----- sv/rgb2g_checker.sv -----
// port-level checker for the rgb to gray stream converter, bound to the top level
`default_nettype none

module rgb2g_checker
    import rgb2g_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_gray_valid,
    input wire logic              i_gray_stall,
    input wire logic [BYTE_W-1:0] o_gray_byte,
    input wire logic              o_is_padding,
    input wire logic              o_row_last,
    input wire logic              o_image_last,
    input wire logic              o_run_last
);

    // a stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gray_valid && i_gray_stall |=> o_gray_valid && $stable(o_gray_byte)
            && $stable(o_is_padding) && $stable(o_row_last) && $stable(o_image_last)
            && $stable(o_run_last))
        else $error("output transaction changed while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gray_valid && o_is_padding |-> o_gray_byte == '0)
        else $error("padding byte not zero");

    a_last_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gray_valid && (o_image_last || o_row_last) |-> o_row_last && o_run_last)
        else $error("row or image end not closing the run");

    // padding bytes of one row come out without a gap
    a_pad_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gray_valid && !i_gray_stall && !o_run_last && (o_is_padding || o_row_last)
            |=> o_gray_valid && o_is_padding)
        else $error("gap inside a padding run");

endmodule

bind rgb_to_gray_average_stream rgb2g_checker u_rgb2g_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_gray_valid (o_gray_valid),
    .i_gray_stall (i_gray_stall),
    .o_gray_byte  (o_gray_byte),
    .o_is_padding (o_is_padding),
    .o_row_last   (o_row_last),
    .o_image_last (o_image_last),
    .o_run_last   (o_run_last)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench of the rgb to gray byte stream converter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rgb2g_pkg::*;

    localparam int MAX_DIM    = 8192;
    localparam int RAND_ITEMS = 420;
    localparam int CALM_ITEMS = 80;
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic [BYTE_W-1:0] gray;
        logic              pad;
        logic              row_last;
        logic              image_last;
        logic              run_last;
    } t_gray_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              i_src_valid;
    logic              o_src_stall;
    logic [BYTE_W-1:0] i_src_byte;
    logic              o_gray_valid;
    logic              i_gray_stall;
    logic [BYTE_W-1:0] o_gray_byte;
    logic              o_is_padding;
    logic              o_row_last;
    logic              o_image_last;
    logic              o_run_last;

    rgb_to_gray_average_stream #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_src_valid  (i_src_valid),
        .o_src_stall  (o_src_stall),
        .i_src_byte   (i_src_byte),
        .o_gray_valid (o_gray_valid),
        .i_gray_stall (i_gray_stall),
        .o_gray_byte  (o_gray_byte),
        .o_is_padding (o_is_padding),
        .o_row_last   (o_row_last),
        .o_image_last (o_image_last),
        .o_run_last   (o_run_last)
    );

    // register copies and converter state of the predictor
    logic [CFG_W-1:0]  cfg_width  = 14'd1;
    logic [CFG_W-1:0]  cfg_height = 14'd1;
    logic              src_fmt    = 1'b0;
    logic [1:0]        px_phase   = '0;
    logic [12:0]       col_idx    = '0;
    logic [12:0]       row_idx    = '0;
    logic [1:0]        skip_left  = '0;
    logic [SUM_W-1:0]  rgb_sum    = '0;

    t_gray_res pending_gray[$];
    t_gray_res head_res;

    bit idle_on;
    bit stall_on;
    int mismatch_cnt;
    int bytes_sent;
    int used_cnt;
    int gray_cnt;
    int reg_writes;
    int cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void push_gray(input logic [BYTE_W-1:0] g, input bit pad,
                                      input bit rlast, input bit ilast, input bit runl);
        t_gray_res r;
        r.gray       = g;
        r.pad        = pad;
        r.row_last   = rlast;
        r.image_last = ilast;
        r.run_last   = runl;
        pending_gray.push_back(r);
    endfunction

    // advances the converter by one source byte; returns 1 when the byte was colour data
    function automatic bit convert_byte(input logic [BYTE_W-1:0] b);
        int w;
        int h;
        int pad_n;
        int k;
        bit last_row;
        logic [BYTE_W-1:0] g;
        if (skip_left != '0) begin
            skip_left = skip_left - 2'd1;
            return 1'b0;
        end
        if (px_phase < src_fmt) begin
            px_phase = px_phase + 2'd1;
            rgb_sum  = '0;
            return 1'b0;
        end
        if (px_phase == src_fmt) rgb_sum = SUM_W'(b);
        else rgb_sum = rgb_sum + SUM_W'(b);
        if (int'(px_phase) < int'(src_fmt) + 2) begin
            px_phase = px_phase + 2'd1;
            return 1'b1;
        end
        px_phase = '0;
        g        = BYTE_W'(int'(rgb_sum) / 3);
        rgb_sum  = '0;
        w = eff_dim(cfg_width);
        h = eff_dim(cfg_height);
        if (int'(col_idx) + 1 < w) begin
            col_idx = col_idx + 13'd1;
            push_gray(g, 1'b0, 1'b0, 1'b0, 1'b1);
            return 1'b1;
        end
        // last column: gray byte, then output row padding up to four-byte alignment
        last_row = (int'(row_idx) + 1 >= h);
        pad_n    = (4 - (w % 4)) % 4;
        push_gray(g, 1'b0, pad_n == 0, last_row && pad_n == 0, pad_n == 0);
        for (k = 1; k <= pad_n; k++)
            push_gray('0, 1'b1, k == pad_n, (k == pad_n) && last_row, k == pad_n);
        col_idx   = '0;
        row_idx   = last_row ? 13'd0 : row_idx + 13'd1;
        skip_left = src_fmt ? 2'd0 : 2'(w % 4);
        return 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(input int small_max);
        case ($urandom_range(0, 11))
            0: return '0;
            1: return CFG_W'(MAX_DIM);
            2: return '1;
            3: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, small_max));
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_src_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_src_valid <= 1'b1;
        i_src_byte  <= b;
        do @(posedge i_clk); while (o_src_stall);
        bytes_sent++;
        if (convert_byte(b)) used_cnt++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width  = val;
            REG_IMAGE_HEIGHT:  cfg_height = val;
            REG_SOURCE_FORMAT: src_fmt    = val[0];
            default: ;
        endcase
    endtask

    // hold the source until every gray byte is back and the pipeline is empty
    task automatic settle();
        @(negedge i_clk);
        i_src_valid <= 1'b0;
        while (pending_gray.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic test_power_on_settings();
        // width 1: three output pad bytes and one skipped source byte per row
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    task automatic test_32bit_pixels();
        settle();
        write_reg(REG_SOURCE_FORMAT, 14'h3FFF);
        write_reg(REG_IMAGE_WIDTH, 14'd4);
        write_reg(REG_IMAGE_HEIGHT, 14'd2);
        write_reg(REG_UNUSED, 14'h3FFF);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'hFF);
    endtask

    task automatic test_dimension_clamp();
        settle();
        // zero width acts as one, so the column already reached ends the row
        write_reg(REG_IMAGE_WIDTH, 14'd0);
        write_reg(REG_IMAGE_HEIGHT, 14'h3FFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle();
        write_reg(REG_IMAGE_WIDTH, 14'(MAX_DIM));
        write_reg(REG_IMAGE_HEIGHT, 14'd0);
        send_byte(8'h11);
        send_byte(8'h80);
        send_byte(8'h40);
        send_byte(8'h20);
        settle();
        // width reduced under a row in progress
        write_reg(REG_IMAGE_WIDTH, 14'd2);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte(8'h01);
    endtask

    task automatic test_format_switch();
        settle();
        write_reg(REG_SOURCE_FORMAT, 14'h0000);
        write_reg(REG_IMAGE_WIDTH, 14'd3);
        write_reg(REG_IMAGE_HEIGHT, 14'd1);
        send_byte(8'h7F);
        settle();
        // first colour byte now counts as the skipped byte position
        write_reg(REG_SOURCE_FORMAT, 14'h0001);
        send_byte(8'h80);
        send_byte(8'h55);
        settle();
        // phase past red position under 24-bit: next byte closes the pixel
        write_reg(REG_SOURCE_FORMAT, 14'h2AAA);
        send_byte(8'hC3);
    endtask

    task automatic test_random_images();
        int start;
        int calm;
        int w;
        int n;
        int i;
        start = bytes_sent;
        while (bytes_sent - start < RAND_ITEMS) begin
            settle();
            if ($urandom_range(0, 1)) write_reg(REG_IMAGE_WIDTH, pick_dim(9));
            if ($urandom_range(0, 1)) write_reg(REG_IMAGE_HEIGHT, pick_dim(3));
            if ($urandom_range(0, 1)) write_reg(REG_SOURCE_FORMAT, CFG_W'($urandom));
            calm     = (bytes_sent - start >= RAND_ITEMS - CALM_ITEMS);
            idle_on  = !calm && ($urandom_range(0, 3) != 0);
            stall_on = !calm && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                // broken sequence: a few stray bytes that shift the pixel alignment
                n = $urandom_range(1, 7);
            end else begin
                w = eff_dim(cfg_width);
                n = (w * (src_fmt ? 4 : 3) + (src_fmt ? 0 : w % 4)) * eff_dim(cfg_height);
                if (n > $urandom_range(20, 60)) n = $urandom_range(20, 60);
            end
            for (i = 0; i < n; i++) send_byte(rand_byte());
        end
    endtask

    // receiver back-pressure in bursts
    initial begin
        i_gray_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_on && $urandom_range(0, 5) == 0) begin
                i_gray_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_gray_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_gray_valid && !i_gray_stall) begin
            if (pending_gray.size() == 0) begin
                $error("unexpected gray transaction: gray_byte %0h", o_gray_byte);
                mismatch_cnt++;
            end else begin
                head_res = pending_gray.pop_front();
                gray_cnt++;
                if (o_gray_byte !== head_res.gray) begin
                    $error("gray_byte: expected %0h, got %0h", head_res.gray, o_gray_byte);
                    mismatch_cnt++;
                end
                if (o_is_padding !== head_res.pad) begin
                    $error("is_padding: expected %0b, got %0b", head_res.pad, o_is_padding);
                    mismatch_cnt++;
                end
                if (o_row_last !== head_res.row_last) begin
                    $error("row_last: expected %0b, got %0b", head_res.row_last, o_row_last);
                    mismatch_cnt++;
                end
                if (o_image_last !== head_res.image_last) begin
                    $error("image_last: expected %0b, got %0b",
                           head_res.image_last, o_image_last);
                    mismatch_cnt++;
                end
                if (o_run_last !== head_res.run_last) begin
                    $error("run_last: expected %0b, got %0b", head_res.run_last, o_run_last);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT) begin
            $display("timeout after %0d cycles, %0d gray bytes outstanding",
                     cycle_cnt, pending_gray.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = REG_IMAGE_WIDTH;
        i_cfg_wdata = '0;
        i_src_valid = 1'b0;
        i_src_byte  = '0;
        idle_on     = 1'b1;
        stall_on    = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_settings();
        test_32bit_pixels();
        test_dimension_clamp();
        test_format_switch();
        test_random_images();

        @(negedge i_clk);
        i_src_valid <= 1'b0;
        while (pending_gray.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("sent %0d source bytes (%0d colour bytes) under %0d register writes",
                 bytes_sent, used_cnt, reg_writes);
        $display("checked %0d gray transactions across 24/32-bit formats and clamped sizes",
                 gray_cnt);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
